/* rtl/pit_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and helpers for the point-in-tetrahedron core.
// No dependencies; every other file imports this package.
package pit_pkg;

  // Coordinate format: signed Q12.8, COORD_BITS of each field are used
  localparam int COORD_BITS = 21;
  localparam int IN_W       = 21;
  localparam int CFG_W      = 63;
  localparam int CFG_IDX_W  = 2;

  // Datapath widths derived from the coordinate width
  localparam int DW    = COORD_BITS + 1;     // vertex difference
  localparam int XW    = 2 * DW + 1;         // cross product component
  localparam int LO_W  = (XW + 1) / 2;       // low slice of a cross component
  localparam int HI_W  = XW - LO_W;          // high (signed) slice
  localparam int PW_LO = DW + LO_W + 1;      // partial product, low slice
  localparam int PW_HI = DW + HI_W;          // partial product, high slice
  localparam int TW    = 3 * DW + 3;         // triple product

  // Weight format
  localparam int QW        = 17;             // quotient bits, 0..65536
  localparam int W_W       = 18;
  localparam int DIV_STEPS = QW;
  localparam logic signed [W_W-1:0] W_MINUS_ONE = W_W'(-65536);
  localparam logic signed [W_W-1:0] W_ONE       = W_W'(65536);

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Number of triple products per point: V, VA, VB, VC, VD
  localparam int NTRI = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTEX_A,
    REG_VERTEX_B,
    REG_VERTEX_C,
    REG_VERTEX_D
  } reg_idx_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DW-1:0]         diff_t;
  typedef logic signed [XW-1:0]         xcomp_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } crd_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
    diff_t z;
  } vec_t;

  typedef struct packed {
    xcomp_t x;
    xcomp_t y;
    xcomp_t z;
  } xvec_t;

  typedef struct packed {
    crd_t a;
    crd_t b;
    crd_t c;
    crd_t d;
  } tet_t;

  // Classified point: inside flag and orientation-normalized volumes
  typedef struct packed {
    logic          in_tet;
    logic [TW-1:0] v;
    logic [TW-1:0] va;
    logic [TW-1:0] vb;
    logic [TW-1:0] vc;
  } cls_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Unpack a vertex register: x low, then y, then z
  function automatic crd_t unpack_vtx(logic [CFG_W-1:0] r);
    crd_t c;
    c.x = coord_t'(r[0 +: COORD_BITS]);
    c.y = coord_t'(r[COORD_BITS +: COORD_BITS]);
    c.z = coord_t'(r[2*COORD_BITS +: COORD_BITS]);
    return c;
  endfunction

  function automatic vec_t vsub(crd_t a, crd_t b);
    vec_t r;
    r.x = diff_t'(a.x) - diff_t'(b.x);
    r.y = diff_t'(a.y) - diff_t'(b.y);
    r.z = diff_t'(a.z) - diff_t'(b.z);
    return r;
  endfunction

  function automatic xvec_t vcross(vec_t b, vec_t c);
    logic signed [2*DW-1:0] p0, p1, p2, p3, p4, p5;
    xvec_t r;
    p0 = b.y * c.z;
    p1 = b.z * c.y;
    p2 = b.z * c.x;
    p3 = b.x * c.z;
    p4 = b.x * c.y;
    p5 = b.y * c.x;
    r.x = xcomp_t'(p0) - xcomp_t'(p1);
    r.y = xcomp_t'(p2) - xcomp_t'(p3);
    r.z = xcomp_t'(p4) - xcomp_t'(p5);
    return r;
  endfunction

  function automatic diff_t vcomp(vec_t v, int k);
    diff_t r;
    case (k)
      0:       r = v.x;
      1:       r = v.y;
      default: r = v.z;
    endcase
    return r;
  endfunction

  function automatic xcomp_t xcomp(xvec_t v, int k);
    xcomp_t r;
    case (k)
      0:       r = v.x;
      1:       r = v.y;
      default: r = v.z;
    endcase
    return r;
  endfunction

endpackage

/* rtl/pit_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for point words and result words.
// Depends on pit_pkg for field widths.
interface pit_in_if;
  import pit_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] point_x;
  logic signed [IN_W-1:0] point_y;
  logic signed [IN_W-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface pit_out_if;
  import pit_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  inside_res;
  logic signed [W_W-1:0] weight_a;
  logic signed [W_W-1:0] weight_b;
  logic signed [W_W-1:0] weight_c;

  modport source (output valid, inside_res, weight_a, weight_b, weight_c, input ready);
  modport sink   (input valid, inside_res, weight_a, weight_b, weight_c, output ready);
endinterface

/* rtl/point_in_tetrahedron_barycentric_core.sv */
`timescale 1ns / 1ps
// Point-in-tetrahedron test with barycentric weights.
// Channels: pt carries point words (signed Q12.8 x, y, z); res carries result
// words (inside flag and the weights of A, B and C in signed Q1.16, all -1.0
// when the point is outside or the tetrahedron is flat).
// Vertices are written through cfg_we / cfg_index / cfg_data while idle.
// Throughput: one point per cycle while the receiver takes every result word.
// Pipeline: 4 front stages forming the triple products, one queue slot, 17 divider
// stages (one quotient bit per stage) and the output register.
// The front end stalls only when the 4-entry queue is full; the back end
// stalls only when its last stage is valid and the output register holds an
// untaken word. A stalled receiver thus fills the divider, then the queue,
// and then drops pt.ready.
// Reset clears all valids, the queue and the vertex registers (all zero, so
// every point reports outside until the vertices are written).
// Depends on pit_pkg, pit_if, pit_front, pit_queue and pit_back.
module point_in_tetrahedron_barycentric_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pit_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pit_pkg::CFG_W-1:0]      cfg_data,
  pit_in_if.sink                         pt,
  pit_out_if.source                      res
);
  import pit_pkg::*;

  logic [CFG_W-1:0] vtx_reg [4];
  tet_t             tet;
  logic             q_push, q_pop;
  cls_t             q_din, q_dout;
  qstat_t           qs;

  // vertex registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) vtx_reg[i] <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_VERTEX_A: vtx_reg[0] <= cfg_data;
        REG_VERTEX_B: vtx_reg[1] <= cfg_data;
        REG_VERTEX_C: vtx_reg[2] <= cfg_data;
        REG_VERTEX_D: vtx_reg[3] <= cfg_data;
      endcase
    end
  end

  assign tet.a = unpack_vtx(vtx_reg[0]);
  assign tet.b = unpack_vtx(vtx_reg[1]);
  assign tet.c = unpack_vtx(vtx_reg[2]);
  assign tet.d = unpack_vtx(vtx_reg[3]);

  pit_front u_front (
    .clk   (clk),
    .rst   (rst),
    .tet   (tet),
    .pt    (pt),
    .qs    (qs),
    .push  (q_push),
    .entry (q_din)
  );

  pit_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_din),
    .pop  (q_pop),
    .dout (q_dout),
    .qs   (qs)
  );

  pit_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (q_dout),
    .qs   (qs),
    .pop  (q_pop),
    .res  (res)
  );

  // front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && qs.full))
    else $error("queue push while full");

  // back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && qs.empty))
    else $error("queue pop while empty");

  // outside words carry -1.0 in every weight
  a_outside_weights: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.inside_res |->
      res.weight_a == W_MINUS_ONE && res.weight_b == W_MINUS_ONE
      && res.weight_c == W_MINUS_ONE)
    else $error("outside word with weight other than -1.0");

  // inside words carry weights within 0..1.0
  a_inside_weights: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.inside_res |->
      res.weight_a >= 0 && res.weight_a <= W_ONE
      && res.weight_b >= 0 && res.weight_b <= W_ONE
      && res.weight_c >= 0 && res.weight_c <= W_ONE)
    else $error("inside word with weight out of range");

endmodule

/* rtl/pit_front.sv */
`timescale 1ns / 1ps
// Front end: accepts point words, forms the five triple products and classifies.
// Depends on pit_pkg and pit_in_if.
module pit_front (
  input  logic           clk,
  input  logic           rst,
  input  pit_pkg::tet_t  tet,
  pit_in_if.sink         pt,
  input  pit_pkg::qstat_t qs,
  output logic           push,
  output pit_pkg::cls_t  entry
);
  import pit_pkg::*;

  // stage valids
  logic v1, v2, v3, v4;

  // stage 1: differences
  vec_t ap1, bp1, ab1, ac1, ad1, bc1, bd1;
  // stage 2: cross products
  xvec_t x_acad2, x_bdbc2, x_adab2, x_abac2;
  vec_t  ap2, bp2, ab2;
  // stage 3: partial products of the dot products
  logic signed [PW_LO-1:0] plo3 [NTRI][3];
  logic signed [PW_HI-1:0] phi3 [NTRI][3];
  // stage 4: triple products
  logic signed [TW-1:0] tri4 [NTRI];

  logic en;
  crd_t p_in;
  vec_t  dot_a [NTRI];
  xvec_t dot_c [NTRI];
  diff_t  op_a [NTRI][3];
  xcomp_t op_c [NTRI][3];
  logic signed [TW-1:0] tri_sum [NTRI];

  // whole front advances unless the last stage is blocked by a full queue
  assign en       = !v4 || !qs.full;
  assign pt.ready = en;
  assign push     = v4 && !qs.full;

  assign p_in.x = coord_t'(pt.point_x[COORD_BITS-1:0]);
  assign p_in.y = coord_t'(pt.point_y[COORD_BITS-1:0]);
  assign p_in.z = coord_t'(pt.point_z[COORD_BITS-1:0]);

  // operand pairing for V, VA, VB, VC, VD
  always_comb begin
    dot_a[0] = ab2; dot_c[0] = x_acad2;
    dot_a[1] = bp2; dot_c[1] = x_bdbc2;
    dot_a[2] = ap2; dot_c[2] = x_acad2;
    dot_a[3] = ap2; dot_c[3] = x_adab2;
    dot_a[4] = ap2; dot_c[4] = x_abac2;
  end

  // per-component operands of the dot products
  always_comb begin
    for (int t = 0; t < NTRI; t++) begin
      for (int k = 0; k < 3; k++) begin
        op_a[t][k] = vcomp(dot_a[t], k);
        op_c[t][k] = xcomp(dot_c[t], k);
      end
    end
  end

  // sum of partial products: hi slice weighted by 2^LO_W
  always_comb begin
    for (int t = 0; t < NTRI; t++) begin
      tri_sum[t] = '0;
      for (int k = 0; k < 3; k++) begin
        tri_sum[t] = tri_sum[t] + (TW'(phi3[t][k]) <<< LO_W) + TW'(plo3[t][k]);
      end
    end
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= pt.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      ap1 <= vsub(p_in, tet.a);
      bp1 <= vsub(p_in, tet.b);
      ab1 <= vsub(tet.b, tet.a);
      ac1 <= vsub(tet.c, tet.a);
      ad1 <= vsub(tet.d, tet.a);
      bc1 <= vsub(tet.c, tet.b);
      bd1 <= vsub(tet.d, tet.b);

      x_acad2 <= vcross(ac1, ad1);
      x_bdbc2 <= vcross(bd1, bc1);
      x_adab2 <= vcross(ad1, ab1);
      x_abac2 <= vcross(ab1, ac1);
      ap2     <= ap1;
      bp2     <= bp1;
      ab2     <= ab1;

      for (int t = 0; t < NTRI; t++) begin
        for (int k = 0; k < 3; k++) begin
          plo3[t][k] <= op_a[t][k] * $signed({1'b0, op_c[t][k][LO_W-1:0]});
          phi3[t][k] <= op_a[t][k] * $signed(op_c[t][k][XW-1:LO_W]);
        end
      end

      for (int t = 0; t < NTRI; t++) begin
        tri4[t] <= tri_sum[t];
      end
    end
  end

  // classification: normalize orientation by the sign of V
  always_comb begin
    logic                 flip;
    logic signed [TW-1:0] n [NTRI];
    flip = tri4[0][TW-1];
    for (int t = 0; t < NTRI; t++) begin
      n[t] = flip ? -tri4[t] : tri4[t];
    end
    entry.in_tet = (n[0] != '0) && !n[1][TW-1] && !n[2][TW-1]
                   && !n[3][TW-1] && !n[4][TW-1];
    entry.v  = n[0];
    entry.va = n[1];
    entry.vb = n[2];
    entry.vc = n[3];
  end

endmodule

/* rtl/pit_queue.sv */
`timescale 1ns / 1ps
// Short queue of classified words between the front and back ends.
// Depends on pit_pkg.
module pit_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pit_pkg::cls_t   din,
  input  logic            pop,
  output pit_pkg::cls_t   dout,
  output pit_pkg::qstat_t qs
);
  import pit_pkg::*;

  cls_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wp, rp;
  logic [QCNT_W-1:0] cnt;

  assign dout     = mem[rp];
  assign qs.full  = (cnt == QCNT_W'(QDEPTH));
  assign qs.empty = (cnt == '0);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      if (push && !pop)      cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

endmodule

/* rtl/pit_back.sv */
`timescale 1ns / 1ps
// Back end: pipelined restoring division of the three sub-volumes by V,
// one quotient bit per stage, and the output register. Depends on pit_pkg, pit_out_if.
module pit_back (
  input  logic            clk,
  input  logic            rst,
  input  pit_pkg::cls_t   head,
  input  pit_pkg::qstat_t qs,
  output logic            pop,
  pit_out_if.source       res
);
  import pit_pkg::*;

  localparam int LAST = DIV_STEPS - 1;

  logic              bv  [DIV_STEPS];
  logic              bin [DIV_STEPS];
  logic [TW-1:0]     bd  [DIV_STEPS];
  logic [TW:0]       r   [3][DIV_STEPS];
  logic [QW-1:0]     q   [3][DIV_STEPS];

  logic              en;
  logic [TW:0]       rin  [3][DIV_STEPS];
  logic [TW:0]       dx   [DIV_STEPS];
  logic              ge   [3][DIV_STEPS];
  logic [TW-1:0]     num  [3];

  // pipeline stalls only when its last word cannot enter the output register
  assign en  = !bv[LAST] || !res.valid || res.ready;
  assign pop = en && !qs.empty;

  assign num[0] = head.va;
  assign num[1] = head.vb;
  assign num[2] = head.vc;

  // per-stage compare: remainder doubles each step after the first
  always_comb begin
    for (int s = 0; s < DIV_STEPS; s++) begin
      dx[s] = (s == 0) ? {1'b0, head.v} : {1'b0, bd[(s == 0) ? 0 : s - 1]};
      for (int j = 0; j < 3; j++) begin
        rin[j][s] = (s == 0) ? {1'b0, num[j]} : (r[j][(s == 0) ? 0 : s - 1] << 1);
        ge[j][s]  = (rin[j][s] >= dx[s]);
      end
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DIV_STEPS; s++) bv[s] <= 1'b0;
    end else if (en) begin
      bv[0] <= pop;
      for (int s = 1; s < DIV_STEPS; s++) bv[s] <= bv[s-1];
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_STEPS; s++) begin
        bin[s] <= (s == 0) ? head.in_tet : bin[(s == 0) ? 0 : s - 1];
        bd[s]  <= dx[s][TW-1:0];
        for (int j = 0; j < 3; j++) begin
          r[j][s] <= ge[j][s] ? (rin[j][s] - dx[s]) : rin[j][s];
          q[j][s] <= (s == 0) ? QW'(ge[j][s])
                              : {q[j][(s == 0) ? 0 : s - 1][QW-2:0], ge[j][s]};
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (!res.valid || res.ready) begin
      res.valid <= bv[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (!res.valid || res.ready) begin
      res.inside_res <= bin[LAST];
      res.weight_a   <= bin[LAST] ? $signed({1'b0, q[0][LAST]}) : W_MINUS_ONE;
      res.weight_b   <= bin[LAST] ? $signed({1'b0, q[1][LAST]}) : W_MINUS_ONE;
      res.weight_c   <= bin[LAST] ? $signed({1'b0, q[2][LAST]}) : W_MINUS_ONE;
    end
  end

endmodule

/* bench/point_in_tetrahedron_barycentric_core_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for the point-in-tetrahedron core: directed points, then
// random tetrahedra and point clouds, each result word checked against a table value or a predictor.
// Depends on pit_pkg, pit_if and the core itself.
module point_in_tetrahedron_barycentric_core_test;
  import pit_pkg::*;

  typedef logic signed [127:0] vol_t;
  typedef struct { longint x; longint y; longint z; } pos_t;
  typedef struct packed {
    logic                  in_tet;
    logic signed [W_W-1:0] wa;
    logic signed [W_W-1:0] wb;
    logic signed [W_W-1:0] wc;
  } weights_t;

  // Directed rows: tet_sel >= 0 loads a vertex set before the row
  typedef struct {
    int tet_sel;
    int x;
    int y;
    int z;
    bit known;
    bit ins;
    int wa;
    int wb;
    int wc;
  } dir_row_t;

  localparam int CMIN = -1048576;
  localparam int CMAX = 1048575;
  localparam int NDIR = 20;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  pit_in_if  pt ();
  pit_out_if res ();

  point_in_tetrahedron_barycentric_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pt        (pt.sink),
    .res       (res.source)
  );

  logic [CFG_W-1:0] tet_regs [4];
  weights_t         pending_weights [$];
  int               errors;
  int               src_idle_pct;
  int               snk_idle_pct;

  dir_row_t dir_rows [NDIR] = '{
    '{-1, 0, 0, 0, 1, 0, -65536, -65536, -65536},
    '{-1, CMAX, CMIN, 5, 1, 0, -65536, -65536, -65536},
    '{0, 0, 0, 0, 1, 1, 65536, 0, 0},
    '{-1, 1024, 0, 0, 1, 1, 0, 65536, 0},
    '{-1, 0, 1024, 0, 1, 1, 0, 0, 65536},
    '{-1, 0, 0, 1024, 1, 1, 0, 0, 0},
    '{-1, 256, 256, 256, 0, 0, 0, 0, 0},
    '{-1, -1, 0, 0, 1, 0, -65536, -65536, -65536},
    '{-1, 512, 512, 0, 0, 0, 0, 0, 0},
    '{-1, CMAX, CMAX, CMAX, 1, 0, -65536, -65536, -65536},
    '{-1, CMIN, CMIN, CMIN, 1, 0, -65536, -65536, -65536},
    '{-1, 100, 200, 300, 0, 0, 0, 0, 0},
    '{1, 100, 200, 300, 0, 0, 0, 0, 0},
    '{-1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{-1, 2000, 0, 0, 1, 0, -65536, -65536, -65536},
    '{2, 0, 0, 0, 1, 0, -65536, -65536, -65536},
    '{-1, 10, 10, 0, 1, 0, -65536, -65536, -65536},
    '{3, 0, 0, 0, 0, 0, 0, 0, 0},
    '{-1, CMIN, CMIN, CMIN, 0, 0, 0, 0, 0},
    '{-1, CMAX, CMAX, CMAX, 0, 0, 0, 0, 0}
  };

  function automatic logic [CFG_W-1:0] pack_vtx(int x, int y, int z);
    logic [31:0] ux, uy, uz;
    ux = x;
    uy = y;
    uz = z;
    return {uz[COORD_BITS-1:0], uy[COORD_BITS-1:0], ux[COORD_BITS-1:0]};
  endfunction

  function automatic pos_t vtx_pos(logic [CFG_W-1:0] r);
    pos_t p;
    p.x = longint'($signed(r[0 +: COORD_BITS]));
    p.y = longint'($signed(r[COORD_BITS +: COORD_BITS]));
    p.z = longint'($signed(r[2*COORD_BITS +: COORD_BITS]));
    return p;
  endfunction

  function automatic pos_t pdiff(pos_t a, pos_t b);
    pos_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  // Six times the signed volume: a . (b x c)
  function automatic vol_t triple_vol(pos_t a, pos_t b, pos_t c);
    longint kx, ky, kz;
    kx = b.y * c.z - b.z * c.y;
    ky = b.z * c.x - b.x * c.z;
    kz = b.x * c.y - b.y * c.x;
    return vol_t'(a.x) * vol_t'(kx) + vol_t'(a.y) * vol_t'(ky) + vol_t'(a.z) * vol_t'(kz);
  endfunction

  function automatic weights_t predict_weights(int px, int py, int pz);
    pos_t a, b, c, d, p, ab, ac, ad, ap, bp;
    vol_t v, va, vb, vc, vd;
    weights_t w;
    logic [31:0] ux, uy, uz;
    a = vtx_pos(tet_regs[REG_VERTEX_A]);
    b = vtx_pos(tet_regs[REG_VERTEX_B]);
    c = vtx_pos(tet_regs[REG_VERTEX_C]);
    d = vtx_pos(tet_regs[REG_VERTEX_D]);
    ux = px;
    uy = py;
    uz = pz;
    p.x = longint'($signed(ux[COORD_BITS-1:0]));
    p.y = longint'($signed(uy[COORD_BITS-1:0]));
    p.z = longint'($signed(uz[COORD_BITS-1:0]));
    ab = pdiff(b, a);
    ac = pdiff(c, a);
    ad = pdiff(d, a);
    ap = pdiff(p, a);
    bp = pdiff(p, b);
    v  = triple_vol(ab, ac, ad);
    va = triple_vol(bp, pdiff(d, b), pdiff(c, b));
    vb = triple_vol(ap, ac, ad);
    vc = triple_vol(ap, ad, ab);
    vd = triple_vol(ap, ab, ac);
    // winding is normalized by the sign of the full volume
    if (v < 0) begin
      v = -v; va = -va; vb = -vb; vc = -vc; vd = -vd;
    end
    if (v != 0 && va >= 0 && vb >= 0 && vc >= 0 && vd >= 0) begin
      w.in_tet = 1'b1;
      w.wa = W_W'((va <<< 16) / v);
      w.wb = W_W'((vb <<< 16) / v);
      w.wc = W_W'((vc <<< 16) / v);
    end else begin
      w.in_tet = 1'b0;
      w.wa = W_MINUS_ONE;
      w.wb = W_MINUS_ONE;
      w.wc = W_MINUS_ONE;
    end
    return w;
  endfunction

  function automatic int clamp_coord(longint v);
    if (v < CMIN) return CMIN;
    if (v > CMAX) return CMAX;
    return int'(v);
  endfunction

  function automatic int near_coord(int ctr, int span);
    return clamp_coord(longint'(ctr) + longint'($urandom_range(2 * span)) - span);
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(CMAX - CMIN)) + CMIN;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall time limit
  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver back-pressure, changed at the falling edge
  always @(negedge clk) begin
    res.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Result checker
  always @(posedge clk) begin
    weights_t w;
    if (!rst && res.valid && res.ready) begin
      if (pending_weights.size() == 0) begin
        $display("%0t: unexpected result word inside=%0b wa=%0d wb=%0d wc=%0d", $time,
                 res.inside_res, res.weight_a, res.weight_b, res.weight_c);
        errors++;
      end else begin
        w = pending_weights.pop_front();
        if (res.inside_res !== w.in_tet) begin
          $display("%0t: inside exp %0b got %0b", $time, w.in_tet, res.inside_res);
          errors++;
        end
        if (res.weight_a !== w.wa) begin
          $display("%0t: weight_a exp %0d got %0d", $time, w.wa, res.weight_a);
          errors++;
        end
        if (res.weight_b !== w.wb) begin
          $display("%0t: weight_b exp %0d got %0d", $time, w.wb, res.weight_b);
          errors++;
        end
        if (res.weight_c !== w.wc) begin
          $display("%0t: weight_c exp %0d got %0d", $time, w.wc, res.weight_c);
          errors++;
        end
      end
    end
  end

  // Wait until every result is back, then let the pipe drain
  task automatic drain_pipe();
    while (pending_weights.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_vertex(reg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    tet_regs[idx] = val;
  endtask

  task automatic load_tet(logic [CFG_W-1:0] a, logic [CFG_W-1:0] b,
                          logic [CFG_W-1:0] c, logic [CFG_W-1:0] d);
    drain_pipe();
    write_vertex(REG_VERTEX_A, a);
    write_vertex(REG_VERTEX_B, b);
    write_vertex(REG_VERTEX_C, c);
    write_vertex(REG_VERTEX_D, d);
  endtask

  task automatic load_directed_tet(int sel);
    case (sel)
      0: load_tet(pack_vtx(0, 0, 0), pack_vtx(1024, 0, 0),
                  pack_vtx(0, 1024, 0), pack_vtx(0, 0, 1024));
      1: load_tet(pack_vtx(0, 0, 0), pack_vtx(0, 1024, 0),
                  pack_vtx(1024, 0, 0), pack_vtx(0, 0, 1024));
      2: load_tet(pack_vtx(0, 0, 0), pack_vtx(1024, 0, 0),
                  pack_vtx(0, 1024, 0), pack_vtx(512, 512, 0));
      default: load_tet(pack_vtx(CMIN, CMIN, CMIN), pack_vtx(CMAX, CMIN, CMIN),
                        pack_vtx(CMIN, CMAX, CMIN), pack_vtx(CMIN, CMIN, CMAX));
    endcase
  endtask

  // Drive one point word; the expectation is queued at acceptance
  task automatic send_point(int x, int y, int z, bit known, weights_t kw);
    logic [31:0] ux, uy, uz;
    ux = x;
    uy = y;
    uz = z;
    while ($urandom_range(99) < src_idle_pct) begin
      pt.valid = 1'b0;
      @(negedge clk);
    end
    pt.valid   = 1'b1;
    pt.point_x = ux[IN_W-1:0];
    pt.point_y = uy[IN_W-1:0];
    pt.point_z = uz[IN_W-1:0];
    do @(posedge clk); while (!pt.ready);
    pending_weights.push_back(known ? kw : predict_weights(x, y, z));
    @(negedge clk);
    pt.valid = 1'b0;
  endtask

  // Stimulus
  initial begin
    weights_t kw;
    int ctr [3];
    int span, px, py, pz, sel, k;
    pos_t vt [4];
    logic [CFG_W-1:0] vr [4];
    errors       = 0;
    src_idle_pct = 34;
    snk_idle_pct = 49;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    pt.valid     = 1'b0;
    pt.point_x   = '0;
    pt.point_y   = '0;
    pt.point_z   = '0;
    res.ready    = 1'b0;
    for (int i = 0; i < 4; i++) tet_regs[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part
    foreach (dir_rows[i]) begin
      if (dir_rows[i].tet_sel >= 0) load_directed_tet(dir_rows[i].tet_sel);
      kw.in_tet = dir_rows[i].ins;
      kw.wa     = W_W'(dir_rows[i].wa);
      kw.wb     = W_W'(dir_rows[i].wb);
      kw.wc     = W_W'(dir_rows[i].wc);
      send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].known, kw);
    end

    // Random part: three idling modes, four tetrahedron sizes each
    for (int mode = 0; mode < 3; mode++) begin
      src_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 49 : 0;
      snk_idle_pct = (mode == 0) ? 49 : (mode == 1) ? 34 : 0;
      for (int sz = 0; sz < 4; sz++) begin
        span = (sz == 0) ? 8 + $urandom_range(56) : (sz == 1) ? 1024 : (sz == 2) ? 100000 :
               CMAX;
        for (int j = 0; j < 3; j++) ctr[j] = (sz == 3) ? 0 : any_coord() / 2;
        for (int v = 0; v < 4; v++) begin
          vr[v] = pack_vtx(near_coord(ctr[0], span), near_coord(ctr[1], span),
                           near_coord(ctr[2], span));
          vt[v] = vtx_pos(vr[v]);
        end
        load_tet(vr[0], vr[1], vr[2], vr[3]);
        for (int n = 0; n < 96; n++) begin
          sel = $urandom_range(99);
          if (sel < 65) begin
            // cloud around the tetrahedron
            px = near_coord(ctr[0], span);
            py = near_coord(ctr[1], span);
            pz = near_coord(ctr[2], span);
          end else if (sel < 80) begin
            // exactly on a vertex or nudged off it
            k  = $urandom_range(3);
            px = clamp_coord(vt[k].x + $urandom_range(2) - 1);
            py = clamp_coord(vt[k].y);
            pz = clamp_coord(vt[k].z + $urandom_range(2) - 1);
          end else begin
            px = any_coord();
            py = any_coord();
            pz = any_coord();
          end
          send_point(px, py, pz, 1'b0, kw);
        end
      end
    end

    drain_pipe();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/pit_pkg.sv
rtl/pit_if.sv
rtl/pit_front.sv
rtl/pit_queue.sv
rtl/pit_back.sv
rtl/point_in_tetrahedron_barycentric_core.sv
bench/point_in_tetrahedron_barycentric_core_test.sv
